/* rtl/utf8v_pkg.sv */
// ----------------------------------------------------------------------------
// utf8v_pkg: shared types and constants for the UTF-8 string validator
// Status codes, byte class masks and the code point admission check.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned PEND_W = 2;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_LENGTH    = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [PEND_W-1:0] pend_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Sequence lengths
  localparam len_t LEN_1 = 3'd1;
  localparam len_t LEN_2 = 3'd2;
  localparam len_t LEN_3 = 3'd3;
  localparam len_t LEN_4 = 3'd4;

  // Lead and continuation byte values
  localparam byte_t B_ASCII_MAX = 8'h7F;
  localparam byte_t B_C0        = 8'hC0;
  localparam byte_t B_C1        = 8'hC1;
  localparam byte_t B_F4        = 8'hF4;
  localparam byte_t MASK_CONT   = 8'h3F;
  localparam byte_t MASK_LEAD2  = 8'h1F;
  localparam byte_t MASK_LEAD3  = 8'h0F;
  localparam byte_t MASK_LEAD4  = 8'h07;

  // Code point limits
  localparam cp_t CP_SURR_LO  = 21'h00D800;
  localparam cp_t CP_SURR_HI  = 21'h00DFFF;
  localparam cp_t CP_MIN3     = 21'h000800;
  localparam cp_t CP_MIN4     = 21'h010000;
  localparam cp_t CP_MAX      = 21'h10FFFF;
  localparam cp_t CP_NONCH_LO = 21'h00FDD0;
  localparam cp_t CP_NONCH_HI = 21'h00FDEF;
  localparam cp_t CP_C0_MAX   = 21'h00001F;
  localparam cp_t CP_DEL      = 21'h00007F;
  localparam cp_t CP_C1_MAX   = 21'h00009F;
  localparam logic [15:0] CP_LOW_FFFE = 16'hFFFE;
  localparam logic [15:0] CP_LOW_FFFF = 16'hFFFF;

  // True when a finished code point of the given sequence length is allowed.
  function automatic logic point_ok(cp_t cp, len_t len);
    logic ok;
    ok = 1'b1;
    if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) ok = 1'b0;
    if (len == LEN_3 && cp < CP_MIN3) ok = 1'b0;
    if (len == LEN_4 && (cp < CP_MIN4 || cp > CP_MAX)) ok = 1'b0;
    if (cp >= CP_NONCH_LO && cp <= CP_NONCH_HI) ok = 1'b0;
    if (cp[15:0] == CP_LOW_FFFE || cp[15:0] == CP_LOW_FFFF) ok = 1'b0;
    if (cp <= CP_C0_MAX || (cp >= CP_DEL && cp <= CP_C1_MAX)) ok = 1'b0;
    return ok;
  endfunction

endpackage

/* rtl/utf8_string_validator.sv */
// ----------------------------------------------------------------------------
// utf8_string_validator: streaming UTF-8 string checker
// Decodes one byte per transfer and reports one status per string.
// ----------------------------------------------------------------------------
//   The slave side carries the string one byte per transfer; tlast marks
//   the final byte. Each byte is decoded combinationally against the
//   running sequence state, so a byte can be accepted on every clock
//   unless a waiting status is held off by the master side. When the final
//   byte is accepted the status (valid, length over MAX_LEN, or malformed)
//   is loaded into the output register and shown on the master side on the
//   next cycle; throughput is one byte per cycle except for that hold-off,
//   bounded by the per-byte decode loop through the sequence state
//   registers. Bytes that are not last produce no transfer. The output
//   register acts as the stage between the two sides: while a status
//   waits to be taken, s_axis_tready stays high as long as the master
//   side takes it in the same cycle; otherwise the slave side holds off
//   until the status transfer completes. Reset clears all sequence state
//   and drops any pending status. After each final byte the state returns
//   to its reset value, ready for the next string.
// ----------------------------------------------------------------------------
module utf8_string_validator #(
  parameter int unsigned MAX_LEN = 65536
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // is_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [1:0] status, [7:2] zero
);

  // Byte counter saturates at MAX_LEN + 1
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 2);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] CNT_OVER  = CNT_W'(MAX_LEN + 1);

  // Sequence state
  utf8v_pkg::pend_t   pending_cont, pending_cont_next;
  utf8v_pkg::len_t    seq_length, seq_length_next;
  utf8v_pkg::cp_t     code_accum, code_accum_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic               error_seen, error_seen_next;
  utf8v_pkg::status_t error_code, error_code_next;

  // Output register
  logic               out_valid;
  utf8v_pkg::status_t out_status, out_status_next;

  // Decode results for the current byte
  utf8v_pkg::pend_t dec_pend;
  utf8v_pkg::len_t  dec_len;
  utf8v_pkg::cp_t   dec_acc;
  logic             dec_bad;
  utf8v_pkg::cp_t   cont_acc;

  logic in_xfer;
  logic out_xfer;
  logic over_len;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = out_valid && m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_status};

  // Shift in the six payload bits of a continuation byte
  assign cont_acc = {code_accum[utf8v_pkg::CP_W-7:0], s_axis_tdata[5:0]};

  // Single-byte decode against the running sequence state
  always_comb begin
    dec_pend = pending_cont;
    dec_len  = seq_length;
    dec_acc  = code_accum;
    dec_bad  = 1'b0;
    if (pending_cont == '0) begin
      if (s_axis_tdata == '0) begin
        dec_bad = 1'b1;
      end else if (s_axis_tdata <= utf8v_pkg::B_ASCII_MAX) begin
        dec_len = utf8v_pkg::LEN_1;
        dec_acc = utf8v_pkg::cp_t'(s_axis_tdata);
        dec_bad = !utf8v_pkg::point_ok(utf8v_pkg::cp_t'(s_axis_tdata), utf8v_pkg::LEN_1);
      end else if (s_axis_tdata[7:5] == 3'b110) begin
        if (s_axis_tdata == utf8v_pkg::B_C0 || s_axis_tdata == utf8v_pkg::B_C1) begin
          dec_bad = 1'b1;
        end else begin
          dec_len  = utf8v_pkg::LEN_2;
          dec_pend = 2'd1;
          dec_acc  = utf8v_pkg::cp_t'(s_axis_tdata & utf8v_pkg::MASK_LEAD2);
        end
      end else if (s_axis_tdata[7:4] == 4'b1110) begin
        dec_len  = utf8v_pkg::LEN_3;
        dec_pend = 2'd2;
        dec_acc  = utf8v_pkg::cp_t'(s_axis_tdata & utf8v_pkg::MASK_LEAD3);
      end else if (s_axis_tdata[7:3] == 5'b11110 && s_axis_tdata <= utf8v_pkg::B_F4) begin
        dec_len  = utf8v_pkg::LEN_4;
        dec_pend = 2'd3;
        dec_acc  = utf8v_pkg::cp_t'(s_axis_tdata & utf8v_pkg::MASK_LEAD4);
      end else begin
        // stray continuation, C0/C1 handled above, F5 and up
        dec_bad = 1'b1;
      end
    end else begin
      if (s_axis_tdata[7:6] != 2'b10) begin
        dec_bad = 1'b1;
      end else begin
        dec_acc  = cont_acc;
        dec_pend = pending_cont - 2'd1;
        // sequence completes: check the finished code point
        if (pending_cont == 2'd1 && !utf8v_pkg::point_ok(cont_acc, seq_length)) begin
          dec_bad = 1'b1;
        end
      end
    end
  end

  // Next-state and status formation
  always_comb begin
    byte_count_next   = (byte_count <= CNT_LIMIT) ? byte_count + 1'b1 : byte_count;
    over_len          = (byte_count_next == CNT_OVER);
    pending_cont_next = pending_cont;
    seq_length_next   = seq_length;
    code_accum_next   = code_accum;
    error_seen_next   = error_seen;
    error_code_next   = error_code;
    out_status_next   = utf8v_pkg::ST_VALID;

    if (over_len) begin
      // length error outranks anything already latched
      error_seen_next = 1'b1;
      error_code_next = utf8v_pkg::ST_LENGTH;
    end else if (!error_seen) begin
      pending_cont_next = dec_pend;
      seq_length_next   = dec_len;
      code_accum_next   = dec_acc;
      if (dec_bad) begin
        error_seen_next = 1'b1;
        error_code_next = utf8v_pkg::ST_MALFORMED;
      end
    end

    // Truncated sequence at end of string
    if (!error_seen_next && pending_cont_next != '0) begin
      out_status_next = utf8v_pkg::ST_MALFORMED;
    end else if (error_seen_next) begin
      out_status_next = error_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_cont <= '0;
      seq_length   <= '0;
      code_accum   <= '0;
      byte_count   <= '0;
      error_seen   <= 1'b0;
      error_code   <= utf8v_pkg::ST_VALID;
      out_valid    <= 1'b0;
    end else begin
      // a new status replaces the one taken in the same cycle
      if (in_xfer && s_axis_tlast) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
      if (in_xfer) begin
        if (s_axis_tlast) begin
          // end of string: return to reset state
          pending_cont <= '0;
          seq_length   <= '0;
          code_accum   <= '0;
          byte_count   <= '0;
          error_seen   <= 1'b0;
          error_code   <= utf8v_pkg::ST_VALID;
        end else begin
          pending_cont <= pending_cont_next;
          seq_length   <= seq_length_next;
          code_accum   <= code_accum_next;
          byte_count   <= byte_count_next;
          error_seen   <= error_seen_next;
          error_code   <= error_code_next;
        end
      end
    end
  end

  // Status payload needs no reset
  always_ff @(posedge clk) begin
    if (in_xfer && s_axis_tlast) begin
      out_status <= out_status_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_last_gives_status : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_axis_tlast) |=> m_axis_tvalid)
    else $error("final byte accepted but no status presented");

  a_mid_no_status : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !s_axis_tlast && (!out_valid || m_axis_tready)) |=> !m_axis_tvalid)
    else $error("status presented for a byte that is not last");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_OVER)
    else $error("byte counter passed its saturation value");

  a_pend_in_seq : assert property (@(posedge clk) disable iff (rst)
    (!error_seen && pending_cont != '0) |-> (seq_length > utf8v_pkg::len_t'(pending_cont)))
    else $error("pending continuation count exceeds sequence length");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3 && m_axis_tdata[7:2] == 6'd0))
    else $error("status transfer carries an undefined code");

endmodule

/* verif/utf8_string_validator_tb.sv */
// ----------------------------------------------------------------------------
// utf8_string_validator_tb: self-checking bench for the UTF-8 string validator
// Feeds strings one byte per transfer, predicts one status per string with
// an independent decoder and compares every status transfer in order.
// ----------------------------------------------------------------------------
module utf8_string_validator_tb;

  localparam int unsigned MAX_LEN      = 65536;
  localparam int          RANDOM_BYTES = 670;
  localparam int          IDLE_PCT     = 31;
  localparam int          DRAIN_CYCLES = 8;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;     // [7:0] data_byte
  logic       s_axis_tlast  = 1'b0;   // is_last
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [1:0] status, [7:2] zero

  // Set during a stretch of the random test: both sides then run flat out.
  bit no_idle = 1'b0;
  int mismatches = 0;

  // Statuses still owed by the block, oldest first.
  utf8v_pkg::status_t status_due[$];

  // Decoder state mirrored by the bench.
  utf8v_pkg::pend_t   want_cont   = '0;
  utf8v_pkg::len_t    seq_len     = '0;
  utf8v_pkg::cp_t     accum       = '0;
  logic [16:0]        seen_bytes  = '0;
  logic               err_latched = 1'b0;
  utf8v_pkg::status_t err_kind    = utf8v_pkg::ST_VALID;

  utf8_string_validator #(
    .MAX_LEN(MAX_LEN)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver: drop tready at random, except inside the no-idle stretch.
  always @(posedge clk) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // A finished code point of a given sequence length is admitted only if it
  // is no surrogate, no overlong or out-of-range form, no noncharacter and
  // no control.
  function automatic logic cp_allowed(utf8v_pkg::cp_t cp, utf8v_pkg::len_t len);
    logic surrogate, overlong, too_big, nonchar, control;
    surrogate = (cp >= utf8v_pkg::CP_SURR_LO) && (cp <= utf8v_pkg::CP_SURR_HI);
    overlong  = ((len == utf8v_pkg::LEN_3) && (cp < utf8v_pkg::CP_MIN3)) ||
                ((len == utf8v_pkg::LEN_4) && (cp < utf8v_pkg::CP_MIN4));
    too_big   = (len == utf8v_pkg::LEN_4) && (cp > utf8v_pkg::CP_MAX);
    nonchar   = ((cp >= utf8v_pkg::CP_NONCH_LO) && (cp <= utf8v_pkg::CP_NONCH_HI)) ||
                (cp[15:0] == utf8v_pkg::CP_LOW_FFFE) || (cp[15:0] == utf8v_pkg::CP_LOW_FFFF);
    control   = (cp <= utf8v_pkg::CP_C0_MAX) ||
                ((cp >= utf8v_pkg::CP_DEL) && (cp <= utf8v_pkg::CP_C1_MAX));
    return !(surrogate || overlong || too_big || nonchar || control);
  endfunction

  // Shortest encoding length of a code point.
  function automatic utf8v_pkg::len_t natural_len(utf8v_pkg::cp_t cp);
    if (cp <= utf8v_pkg::cp_t'(utf8v_pkg::B_ASCII_MAX)) return utf8v_pkg::LEN_1;
    if (cp < utf8v_pkg::CP_MIN3) return utf8v_pkg::LEN_2;
    if (cp < utf8v_pkg::CP_MIN4) return utf8v_pkg::LEN_3;
    return utf8v_pkg::LEN_4;
  endfunction

  // Latch a malformed status unless some error is already held.
  task automatic mark_malformed();
    if (!err_latched) begin
      err_latched = 1'b1;
      err_kind    = utf8v_pkg::ST_MALFORMED;
    end
  endtask

  // Advance the mirrored decoder by one accepted byte; on the last byte of
  // a string queue the status it must produce and clear the state.
  task automatic predict_status(input utf8v_pkg::byte_t b, input logic last);
    if (seen_bytes <= MAX_LEN) seen_bytes = seen_bytes + 17'd1;

    if (seen_bytes > MAX_LEN) begin
      // Length overflow outranks anything latched before.
      err_latched = 1'b1;
      err_kind    = utf8v_pkg::ST_LENGTH;
    end else if (!err_latched) begin
      if (want_cont == '0) begin
        if (b == '0) begin
          mark_malformed();
        end else if (b <= utf8v_pkg::B_ASCII_MAX) begin
          seq_len = utf8v_pkg::LEN_1;
          accum   = utf8v_pkg::cp_t'(b);
          if (!cp_allowed(accum, utf8v_pkg::LEN_1)) mark_malformed();
        end else if (b[7:5] == 3'b110) begin
          if (b == utf8v_pkg::B_C0 || b == utf8v_pkg::B_C1) begin
            mark_malformed();
          end else begin
            seq_len   = utf8v_pkg::LEN_2;
            want_cont = utf8v_pkg::pend_t'(1);
            accum     = utf8v_pkg::cp_t'(b & utf8v_pkg::MASK_LEAD2);
          end
        end else if (b[7:4] == 4'b1110) begin
          seq_len   = utf8v_pkg::LEN_3;
          want_cont = utf8v_pkg::pend_t'(2);
          accum     = utf8v_pkg::cp_t'(b & utf8v_pkg::MASK_LEAD3);
        end else if (b[7:3] == 5'b11110 && b <= utf8v_pkg::B_F4) begin
          seq_len   = utf8v_pkg::LEN_4;
          want_cont = utf8v_pkg::pend_t'(3);
          accum     = utf8v_pkg::cp_t'(b & utf8v_pkg::MASK_LEAD4);
        end else begin
          // Stray continuation or a lead that can never start a sequence.
          mark_malformed();
        end
      end else if (b[7:6] != 2'b10) begin
        mark_malformed();
      end else begin
        accum     = {accum[utf8v_pkg::CP_W-7:0], b[5:0]};
        want_cont = want_cont - utf8v_pkg::pend_t'(1);
        if (want_cont == '0 && !cp_allowed(accum, seq_len)) mark_malformed();
      end
    end

    if (last) begin
      // A sequence cut off by the end of the string is malformed.
      if (!err_latched && want_cont != '0) mark_malformed();
      status_due.push_back(err_latched ? err_kind : utf8v_pkg::ST_VALID);
      want_cont   = '0;
      seq_len     = '0;
      accum       = '0;
      seen_bytes  = '0;
      err_latched = 1'b0;
      err_kind    = utf8v_pkg::ST_VALID;
    end
  endtask

  // Send one byte: idle at random first (scrambling the data bus meanwhile),
  // then hold tvalid until the transfer completes and predict it.
  task automatic send_byte(input utf8v_pkg::byte_t b, input logic last);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= utf8v_pkg::byte_t'($urandom);
        s_axis_tlast  <= 1'($urandom_range(1, 0));
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_status(b, last);
  endtask

  task automatic send_string(input utf8v_pkg::byte_t bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // One-byte strings: plain ASCII, NUL, DEL, a byte that never leads, a
  // stray continuation and an overlong two-byte lead.
  task automatic test_single_bytes();
    utf8v_pkg::byte_t singles[6] = '{8'h41, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'hC0};
    foreach (singles[i]) send_byte(singles[i], 1'b1);
  endtask

  // Full sequences: valid two- and four-byte forms, an overlong three-byte
  // form, a surrogate and a code point past the top of the range.
  task automatic test_sequences();
    utf8v_pkg::byte_t s[$];
    s = {8'hC3, 8'hA9};               send_string(s);
    s = {8'hE0, 8'h80, 8'h80};        send_string(s);
    s = {8'hED, 8'hA0, 8'h80};        send_string(s);
    s = {8'hF4, 8'h90, 8'h80, 8'h80}; send_string(s);
    s = {8'hF0, 8'h9F, 8'h98, 8'h80}; send_string(s);
  endtask

  // A sequence cut off by the end of the string, and one broken by an
  // ASCII byte where a continuation belongs.
  task automatic test_truncation();
    utf8v_pkg::byte_t s[$];
    s = {8'hE2, 8'h82}; send_string(s);
    s = {8'hC3, 8'h41}; send_string(s);
  endtask

  // Random strings built mostly from well-formed sequences with random
  // content, mixed with edge code points, raw noise, corrupted bytes and
  // cut-off endings.
  task automatic test_random_strings();
    utf8v_pkg::byte_t str[$];
    utf8v_pkg::cp_t   cp;
    utf8v_pkg::len_t  len;
    logic  raw;
    int    sent, n_points, pick;
    logic [4:0] plane;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      no_idle = (sent >= 250) && (sent < 400);
      str.delete();
      n_points = $urandom_range(6, 1);
      repeat (n_points) begin
        raw = 1'b0;
        len = utf8v_pkg::len_t'($urandom_range(4, 1));
        case (len)
          utf8v_pkg::LEN_1: cp = utf8v_pkg::cp_t'($urandom_range(8'h7E, 8'h20));
          utf8v_pkg::LEN_2: cp = utf8v_pkg::cp_t'($urandom_range(12'h7FF, 8'hA0));
          utf8v_pkg::LEN_3: cp = utf8v_pkg::cp_t'($urandom_range(16'hFFFD, 16'h0800));
          default:          cp = utf8v_pkg::cp_t'($urandom_range(21'h10FFFD, 21'h010000));
        endcase
        if ($urandom_range(99) < 40) begin
          pick = $urandom_range(7, 0);
          case (pick)
            0: begin
              len = utf8v_pkg::LEN_3;
              cp  = utf8v_pkg::cp_t'($urandom_range(utf8v_pkg::CP_SURR_HI,
                                                    utf8v_pkg::CP_SURR_LO));
            end
            1: begin
              len = utf8v_pkg::LEN_3;
              cp  = utf8v_pkg::cp_t'($urandom_range(utf8v_pkg::CP_NONCH_HI,
                                                    utf8v_pkg::CP_NONCH_LO));
            end
            2: begin
              // xxFFFE / xxFFFF in any plane
              plane = 5'($urandom_range(16, 0));
              cp    = {plane, 15'h7FFF, 1'($urandom_range(1, 0))};
              len   = natural_len(cp);
            end
            3: begin
              // C0 and C1 controls, DEL included
              cp  = ($urandom_range(1, 0) != 0) ?
                    utf8v_pkg::cp_t'($urandom_range(utf8v_pkg::CP_C0_MAX, 0)) :
                    utf8v_pkg::cp_t'($urandom_range(utf8v_pkg::CP_C1_MAX, utf8v_pkg::CP_DEL));
              len = natural_len(cp);
            end
            4: begin
              // overlong forms
              len = utf8v_pkg::len_t'($urandom_range(4, 2));
              case (len)
                utf8v_pkg::LEN_2: cp = utf8v_pkg::cp_t'($urandom_range(8'h7F, 0));
                utf8v_pkg::LEN_3: cp = utf8v_pkg::cp_t'($urandom_range(12'h7FF, 0));
                default:          cp = utf8v_pkg::cp_t'($urandom_range(16'hFFFF, 0));
              endcase
            end
            5: begin
              // past the top of the range, leads F4 through F7
              len = utf8v_pkg::LEN_4;
              cp  = utf8v_pkg::cp_t'($urandom_range(21'h1FFFFF, 21'h110000));
            end
            6: begin
              case ($urandom_range(9, 0))
                0:       cp = 21'h00007E;
                1:       cp = 21'h0000A0;
                2:       cp = 21'h0007FF;
                3:       cp = utf8v_pkg::CP_MIN3;
                4:       cp = 21'h00D7FF;
                5:       cp = 21'h00E000;
                6:       cp = 21'h00FDCF;
                7:       cp = 21'h00FDF0;
                8:       cp = utf8v_pkg::CP_MIN4;
                default: cp = utf8v_pkg::CP_MAX;
              endcase
              len = natural_len(cp);
            end
            default: raw = 1'b1;
          endcase
        end
        if (raw) begin
          repeat ($urandom_range(3, 1)) str.push_back(utf8v_pkg::byte_t'($urandom));
        end else begin
          case (len)
            utf8v_pkg::LEN_1: str.push_back(cp[7:0]);
            utf8v_pkg::LEN_2: begin
              str.push_back({3'b110, cp[10:6]});
              str.push_back({2'b10, cp[5:0]});
            end
            utf8v_pkg::LEN_3: begin
              str.push_back({4'b1110, cp[15:12]});
              str.push_back({2'b10, cp[11:6]});
              str.push_back({2'b10, cp[5:0]});
            end
            default: begin
              str.push_back({5'b11110, cp[20:18]});
              str.push_back({2'b10, cp[17:12]});
              str.push_back({2'b10, cp[11:6]});
              str.push_back({2'b10, cp[5:0]});
            end
          endcase
        end
      end
      // Damage a share of the strings: cut the tail or overwrite one byte.
      pick = $urandom_range(99, 0);
      if (pick < 10 && str.size() > 1) begin
        void'(str.pop_back());
      end else if (pick < 20) begin
        str[$urandom_range(str.size() - 1, 0)] = utf8v_pkg::byte_t'($urandom);
      end
      send_string(str);
      sent += str.size();
    end
    no_idle = 1'b0;
  endtask

  // Check each status transfer against the oldest expected status.
  always @(posedge clk) begin : result_check
    logic [7:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %02h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = {6'b0, status_due.pop_front()};
        if (m_axis_tdata !== want) begin
          $display("%0t: result mismatch: expected %02h, actual %02h",
                   $time, want, m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  initial begin
    // Hold reset at the start, then release it once for the whole run.
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_bytes();
    test_sequences();
    test_truncation();
    test_random_strings();

    // Stop sending, drain outstanding statuses, then allow a few more cycles
    // so a spurious late transfer still gets caught.
    s_axis_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/utf8v_pkg.sv
rtl/utf8_string_validator.sv
verif/utf8_string_validator_tb.sv
